// File: rtl/tcc_pkg.sv
// Shared types and constants for the text console with cursor and scrolling.
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

  // Operation codes carried by a request.
  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_WRITE,
    S_SCROLL,
    S_FILL,
    S_RD,
    S_POS,
    S_DONE
  } state_e;

  localparam int unsigned CELL_W = 16;

  // Character codes with special handling.
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;

  // Attribute after reset, and the blank cell the buffer holds after reset.
  localparam logic [7:0]        ATTR_RESET  = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_RESET = {ATTR_RESET, CH_SPACE};

endpackage

`default_nettype wire

// File: rtl/tcc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tcc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/text_console_cursor_scroll_top.sv
// Text console: screen buffer, cursor, scrolling and cell readback under one sequencer.
// Each request passes EXEC and then POS and DONE; a put also passes WRITE, a read RD,
// a put that scrolls SCROLL and FILL, and a clear FILL over the whole buffer.
// One request at a time; the next is taken in the cycle after its result is registered.
// After reset the buffer is blanked with attribute 0x07, one cell per cycle;
// requests stall meanwhile, attribute writes are taken.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_scroll_top
  import tcc_pkg::*;
#(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STOP = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  // Attribute register write port.
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,

  // Request channel.
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [4:0]  row_i,
  input  wire logic [6:0]  col_i,

  // Result channel.
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [4:0]       cursor_row_o,
  output logic [6:0]       cursor_col_o,
  output logic [10:0]      cursor_position_o,
  output logic [15:0]      cell_data_o
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned PW    = $clog2(CELLS);
  localparam int unsigned TW    = $clog2(COLUMNS + TAB_STOP);

  // Next tab stop for every column, fixed at elaboration.
  logic [TW-1:0] tab_tbl [COLUMNS];
  for (genvar g = 0; g < COLUMNS; g++) begin : g_tab
    assign tab_tbl[g] = TW'((g / TAB_STOP + 1) * TAB_STOP);
  end

  state_e state_q, state_d;

  logic [7:0]    attr_q;
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [PW-1:0] ptr_q, ptr_d;
  logic          out_valid_q, out_valid_d;

  // Latched request and working values.
  op_e           op_q, op_d;
  logic [7:0]    ch_q, ch_d;
  logic [RW-1:0] rowc_q, rowc_d;
  logic [CW-1:0] colc_q, colc_d;
  logic [PW-1:0] addr_q, addr_d;
  logic [7:0]    wch_q, wch_d;
  logic          wr_q, wr_d;
  logic          scroll_q, scroll_d;

  logic [4:0]    out_row_q, out_row_d;
  logic [6:0]    out_col_q, out_col_d;
  logic [10:0]   out_pos_q, out_pos_d;
  logic [15:0]   out_data_q, out_data_d;

  // Shared address unit: row times COLUMNS plus column.
  logic [RW-1:0] au_row;
  logic [CW-1:0] au_col;
  logic [PW-1:0] au_sum;

  // Buffer port controls.
  logic              ram_we, ram_re;
  logic [PW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic          accept;
  logic          out_free;
  logic [TW-1:0] tab_next;

  assign accept   = (state_q == S_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign tab_next = tab_tbl[cur_col_q];
  assign au_sum   = PW'(int'(au_row) * COLUMNS) + PW'(au_col);

  always_comb begin
    state_d     = state_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    ptr_d       = ptr_q;
    out_valid_d = out_valid_q && out_stall_i;
    op_d        = op_q;
    ch_d        = ch_q;
    rowc_d      = rowc_q;
    colc_d      = colc_q;
    addr_d      = addr_q;
    wch_d       = wch_q;
    wr_d        = wr_q;
    scroll_d    = scroll_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_pos_d   = out_pos_q;
    out_data_d  = out_data_q;
    au_row      = cur_row_q;
    au_col      = cur_col_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = ptr_q;
    ram_raddr   = addr_q;
    ram_wdata   = {attr_q, CH_SPACE};

    unique case (state_q)
      S_INIT: begin
        // Post-reset blanking pass with the fixed reset attribute.
        ram_we    = 1'b1;
        ram_wdata = BLANK_RESET;
        if (ptr_q == PW'(CELLS - 1)) begin
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (accept) begin
          op_d   = op_e'(operation_i);
          ch_d   = char_code_i;
          // Out-of-range coordinates clamp to the last row and column.
          rowc_d = (int'(row_i) > ROWS - 1) ? RW'(ROWS - 1) : RW'(row_i);
          colc_d = (int'(col_i) > COLUMNS - 1) ? CW'(COLUMNS - 1) : CW'(col_i);
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        wr_d     = 1'b0;
        scroll_d = 1'b0;
        wch_d    = CH_SPACE;
        unique case (op_q)
          OP_PUT: begin
            // The cell write always uses the row before the cursor moves.
            priority if (ch_q == CH_NEWLINE) begin
              cur_col_d = '0;
              if (cur_row_q == RW'(ROWS - 1)) begin
                scroll_d = 1'b1;
              end else begin
                cur_row_d = cur_row_q + 1'b1;
              end
            end else if (ch_q == CH_RETURN) begin
              cur_col_d = '0;
            end else if (ch_q == CH_TAB) begin
              if (tab_next >= TW'(COLUMNS)) begin
                cur_col_d = '0;
                if (cur_row_q == RW'(ROWS - 1)) begin
                  scroll_d = 1'b1;
                end else begin
                  cur_row_d = cur_row_q + 1'b1;
                end
              end else begin
                cur_col_d = CW'(tab_next);
              end
            end else if (ch_q == CH_BACKSPACE) begin
              // Nothing happens at the left edge.
              if (cur_col_q != '0) begin
                au_col    = cur_col_q - 1'b1;
                cur_col_d = cur_col_q - 1'b1;
                wr_d      = 1'b1;
              end
            end else begin
              wr_d  = 1'b1;
              wch_d = ch_q;
              if (cur_col_q == CW'(COLUMNS - 1)) begin
                cur_col_d = '0;
                if (cur_row_q == RW'(ROWS - 1)) begin
                  scroll_d = 1'b1;
                end else begin
                  cur_row_d = cur_row_q + 1'b1;
                end
              end else begin
                cur_col_d = cur_col_q + 1'b1;
              end
            end
            addr_d = au_sum;
            ptr_d  = '0;
            state_d = S_WRITE;
          end
          OP_SET: begin
            cur_row_d = rowc_q;
            cur_col_d = colc_q;
            state_d   = S_POS;
          end
          OP_CLEAR: begin
            cur_row_d = '0;
            cur_col_d = '0;
            ptr_d     = '0;
            state_d   = S_FILL;
          end
          OP_READ: begin
            au_row  = rowc_q;
            au_col  = colc_q;
            addr_d  = au_sum;
            state_d = S_RD;
          end
        endcase
      end

      S_WRITE: begin
        ram_we    = wr_q;
        ram_waddr = addr_q;
        ram_wdata = {attr_q, wch_q};
        state_d   = scroll_q ? S_SCROLL : S_POS;
      end

      S_SCROLL: begin
        // Copy each row up by one: read a cell one row below the pointer while
        // the cell read in the previous cycle lands one place behind it.
        ram_re    = (ptr_q != PW'(CELLS - COLUMNS));
        ram_raddr = ptr_q + PW'(COLUMNS);
        ram_we    = (ptr_q != '0);
        ram_waddr = ptr_q - 1'b1;
        ram_wdata = ram_rdata;
        if (ptr_q == PW'(CELLS - COLUMNS)) begin
          // The bottom row is blanked next, from where the pointer stands.
          state_d = S_FILL;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      S_FILL: begin
        ram_we = 1'b1;
        if (ptr_q == PW'(CELLS - 1)) begin
          state_d = S_POS;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_POS;
      end

      S_POS: begin
        addr_d  = au_sum;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_row_d   = 5'(cur_row_q);
          out_col_d   = 7'(cur_col_q);
          out_pos_d   = 11'(addr_q);
          out_data_d  = (op_q == OP_READ) ? ram_rdata : '0;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= ATTR_RESET;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    ch_q       <= ch_d;
    rowc_q     <= rowc_d;
    colc_q     <= colc_d;
    addr_q     <= addr_d;
    wch_q      <= wch_d;
    wr_q       <= wr_d;
    scroll_q   <= scroll_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_pos_q  <= out_pos_d;
    out_data_q <= out_data_d;
  end

  // Screen buffer.
  tcc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign cursor_row_o      = out_row_q;
  assign cursor_col_o      = out_col_q;
  assign cursor_position_o = out_pos_q;
  assign cell_data_o       = out_data_q;

endmodule

`default_nettype wire
